[hdl/bic_pkg.sv]
// shared types, constants and codes of the component labeler
package bic_pkg;

  localparam int PIX_W     = 8;
  localparam int LBL_W     = 18;
  localparam int CNT_W     = 19;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(512);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(512);
  localparam logic [PIX_W-1:0] FG_RST     = PIX_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_FG     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] pixel;
  } req_t;

  typedef struct packed {
    logic             is_foreground;
    logic [LBL_W-1:0] label;
    logic [CNT_W-1:0] component_count;
    logic             last;
  } res_t;

  // neighbour slots of the current pixel
  typedef enum logic [1:0] {
    NB_L  = 2'd0,
    NB_UL = 2'd1,
    NB_UP = 2'd2,
    NB_UR = 2'd3
  } nb_e;

  // read address source of the parent table
  typedef enum logic [1:0] {
    EPR_PAR  = 2'd0,
    EPR_WALK = 2'd1,
    EPR_PIX  = 2'd2
  } ep_rsel_e;

  // start of a root walk
  typedef enum logic [1:0] {
    WS_MAX = 2'd0,
    WS_MIN = 2'd1,
    WS_IDX = 2'd2
  } walk_src_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_NB1,
    S_NB2,
    S_NB3,
    S_NB4,
    S_DEC,
    S_LAB,
    S_LAB_W,
    S_W1_RD,
    S_W1_CK,
    S_W2_RD,
    S_W2_CK,
    S_ADV,
    S_RS_CHK,
    S_RS_RD,
    S_RS_CK,
    S_R_PL,
    S_R_EP,
    S_R_DN,
    S_R_OUT
  } state_e;

  typedef struct packed {
    logic      accept;
    logic      bg_wr;
    nb_e       nb_sel;
    logic      nb_cap;
    nb_e       nb_cap_idx;
    logic      decide;
    ep_rsel_e  ep_rsel;
    logic      fresh_wr;
    logic      par_wr;
    logic      walk_init;
    walk_src_e walk_src;
    logic      walk_step;
    logic      save_ra;
    logic      union_wr;
    logic      advance;
    logic      res_init;
    logic      res_wr;
    logic      done_set;
    logic      pl_rd_rpos;
    logic      emit;
    logic      emit_fg;
  } cmd_t;

  typedef struct packed {
    logic pix_fg;
    logic done;
    logic have1;
    logic have2;
    logic ab_differ;
    logic walk_done;
    logic frame_end;
    logic res_more;
    logic pl_bg;
  } status_t;

endpackage

[hdl/binary_image_component_labeler.sv]
// top level of the binary image component labeler
//
//  channel   ports                                   direction  transfer
//  request   start, busy, req_i                      in         start high while busy low
//  result    result_valid_o, result_o                out        one cycle strobe, no stall
//  config    cfg_we_i, cfg_idx_i, cfg_data_i         in         every cycle cfg_we_i is high
//
// background pixel load: load, advance; foreground load: load, four neighbour reads,
//   decision, then a fresh label or a parent read and write of the neighbour label, plus a
//   read and a check per check of each root walk in the parent table (walk steps + 1) when
//   two neighbour labels merge; the last load of a frame adds the resolve sweep: a check,
//   read and walk check per label, a read and check per walk step, and a closing check
// readout: the label table read, which ends a background one; foreground adds the parent
//   and dense number reads (three chained ram reads); an unfinished frame gives no result
// reset clears control state only; the label stores need no clearing pass
// results are shown for one cycle and cannot be held off by the receiver
module binary_image_component_labeler #(
  parameter int MAX_WIDTH  = bic_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bic_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bic_pkg::req_t                 req_i,
  output logic                          result_valid_o,
  output bic_pkg::res_t                 result_o,
  input  logic                          cfg_we_i,
  input  logic [bic_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bic_pkg::CFG_W-1:0]     cfg_data_i
);
  import bic_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: one state per ram access step
  bic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_load_i (req_i.req_type == 1'b0),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  // counters, label stores and the result register
  bic_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

[hdl/bic_ram.sv]
// simple dual-port ram with registered read
module bic_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/bic_ctrl.sv]
// sequencer of the component labeler
module bic_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             req_load_i,
  input  bic_pkg::status_t status_i,
  output bic_pkg::cmd_t    cmd_o,
  output logic             busy_o
);
  import bic_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.ep_rsel = EPR_WALK;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if (req_load_i) begin
            state_d = S_LOAD;
          end else if (status_i.done) begin
            state_d = S_R_PL;
          end
        end
      end
      S_LOAD: begin
        if (status_i.pix_fg) begin
          cmd_o.nb_sel = NB_L;
          state_d = S_NB1;
        end else begin
          cmd_o.bg_wr = 1'b1;
          state_d = S_ADV;
        end
      end
      S_NB1: begin
        cmd_o.nb_sel = NB_UL;
        cmd_o.nb_cap = 1'b1;
        cmd_o.nb_cap_idx = NB_L;
        state_d = S_NB2;
      end
      S_NB2: begin
        cmd_o.nb_sel = NB_UP;
        cmd_o.nb_cap = 1'b1;
        cmd_o.nb_cap_idx = NB_UL;
        state_d = S_NB3;
      end
      S_NB3: begin
        cmd_o.nb_sel = NB_UR;
        cmd_o.nb_cap = 1'b1;
        cmd_o.nb_cap_idx = NB_UP;
        state_d = S_NB4;
      end
      S_NB4: begin
        cmd_o.nb_cap = 1'b1;
        cmd_o.nb_cap_idx = NB_UR;
        state_d = S_DEC;
      end
      S_DEC: begin
        cmd_o.decide = 1'b1;
        state_d = S_LAB;
      end
      S_LAB: begin
        if (status_i.have1) begin
          cmd_o.ep_rsel = EPR_PAR;
          state_d = S_LAB_W;
        end else begin
          cmd_o.fresh_wr = 1'b1;
          state_d = S_ADV;
        end
      end
      S_LAB_W: begin
        cmd_o.par_wr = 1'b1;
        if (status_i.have2 && status_i.ab_differ) begin
          cmd_o.walk_init = 1'b1;
          cmd_o.walk_src = WS_MAX;
          state_d = S_W1_RD;
        end else begin
          state_d = S_ADV;
        end
      end
      S_W1_RD: state_d = S_W1_CK;
      S_W1_CK: begin
        if (status_i.walk_done) begin
          cmd_o.save_ra = 1'b1;
          cmd_o.walk_init = 1'b1;
          cmd_o.walk_src = WS_MIN;
          state_d = S_W2_RD;
        end else begin
          cmd_o.walk_step = 1'b1;
          state_d = S_W1_RD;
        end
      end
      S_W2_RD: state_d = S_W2_CK;
      S_W2_CK: begin
        if (status_i.walk_done) begin
          cmd_o.union_wr = 1'b1;
          state_d = S_ADV;
        end else begin
          cmd_o.walk_step = 1'b1;
          state_d = S_W2_RD;
        end
      end
      S_ADV: begin
        cmd_o.advance = 1'b1;
        if (status_i.frame_end) begin
          cmd_o.res_init = 1'b1;
          state_d = S_RS_CHK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RS_CHK: begin
        if (status_i.res_more) begin
          cmd_o.walk_init = 1'b1;
          cmd_o.walk_src = WS_IDX;
          state_d = S_RS_RD;
        end else begin
          cmd_o.done_set = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RS_RD: state_d = S_RS_CK;
      S_RS_CK: begin
        if (status_i.walk_done) begin
          cmd_o.res_wr = 1'b1;
          state_d = S_RS_CHK;
        end else begin
          cmd_o.walk_step = 1'b1;
          state_d = S_RS_RD;
        end
      end
      S_R_PL: begin
        cmd_o.pl_rd_rpos = 1'b1;
        state_d = S_R_EP;
      end
      S_R_EP: begin
        cmd_o.ep_rsel = EPR_PIX;
        if (status_i.pl_bg) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_R_DN;
        end
      end
      S_R_DN: state_d = S_R_OUT;
      S_R_OUT: begin
        cmd_o.emit = 1'b1;
        cmd_o.emit_fg = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

[hdl/bic_dp.sv]
// datapath of the component labeler: counters, tables and result register
module bic_dp #(
  parameter int MAX_WIDTH  = bic_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bic_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bic_pkg::req_t                   req_i,
  input  logic                            cfg_we_i,
  input  logic [bic_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bic_pkg::CFG_W-1:0]       cfg_data_i,
  input  bic_pkg::cmd_t                   cmd_i,
  output bic_pkg::status_t                status_o,
  output logic                            result_valid_o,
  output bic_pkg::res_t                   result_o
);
  import bic_pkg::*;

  localparam int CAP = MAX_WIDTH * MAX_HEIGHT;
  localparam int LW  = $clog2(CAP);
  localparam int TW  = LW + 1;
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam logic [LW-1:0] LBL_TOP = LW'(CAP - 1);

  // configuration
  logic [CFG_W-1:0] width_q, height_q;
  logic [PIX_W-1:0] fg_val_q;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [TW-1:0]    total_q;

  // frame control
  logic [XW-1:0] x_q;
  logic [YW-1:0] y_q;
  logic [LW-1:0] pos_q, rpos_q;
  logic [TW-1:0] next_label_q, roots_q, i_q;
  logic          done_q;
  logic          restart;

  // per-pixel working registers
  logic [PIX_W-1:0] pix_q;
  logic [3:0]       nb_fg_q;
  logic [LW-1:0]    nb_lab_q [4];
  logic             have1_q, have2_q;
  logic [LW-1:0]    a_q, b_q, l_q, ra_q;
  logic             valid_q;
  res_t             res_q;

  // ram ports
  logic          pl_we, ep_we, dn_we;
  logic [LW-1:0] pl_waddr, ep_waddr, dn_waddr, pl_raddr, ep_raddr;
  logic [LW:0]   pl_wdata, pl_rdata;
  logic [LW-1:0] ep_wdata, ep_rdata, dn_wdata, dn_rdata;

  logic          x_gt0, y_gt0, x_last, y_last, ur_ok;
  logic          left, ul, up, ur, have1, have2;
  nb_e           s1, s2;
  logic [LW-1:0] w_l, fresh, ab_max, ab_min, walk_start;
  logic          last_pix;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_q);
    end
  end

  assign restart = cfg_we_i && (cfg_idx_i == CFG_WIDTH || cfg_idx_i == CFG_HEIGHT
                                || cfg_idx_i == CFG_FG);

  assign w_l    = LW'(w_eff);
  assign x_gt0  = (x_q != '0);
  assign y_gt0  = (y_q != '0);
  assign x_last = ((WW'(x_q) + WW'(1)) >= w_eff);
  assign y_last = ((HW'(y_q) + HW'(1)) >= h_eff);
  assign ur_ok  = ((WW'(x_q) + WW'(1)) < w_eff);

  assign left = x_gt0 && nb_fg_q[NB_L];
  assign ul   = x_gt0 && y_gt0 && nb_fg_q[NB_UL];
  assign up   = y_gt0 && nb_fg_q[NB_UP];
  assign ur   = y_gt0 && ur_ok && nb_fg_q[NB_UR];

  // neighbour choice in the fixed priority order
  always_comb begin
    have1 = 1'b0;
    have2 = 1'b0;
    s1    = NB_L;
    s2    = NB_L;
    if (left) begin
      have1 = 1'b1;
      if (y_gt0) begin
        if (!ul) begin
          if (up) begin
            have2 = 1'b1;
            s2 = NB_UP;
          end else if (ur) begin
            have2 = 1'b1;
            s2 = NB_UR;
          end
        end else if (!up && ur) begin
          have2 = 1'b1;
          s2 = NB_UR;
        end
      end
    end else if (y_gt0) begin
      if (up) begin
        have1 = 1'b1;
        s1 = NB_UP;
      end else if (ul) begin
        have1 = 1'b1;
        s1 = NB_UL;
        if (ur) begin
          have2 = 1'b1;
          s2 = NB_UR;
        end
      end else if (ur) begin
        have1 = 1'b1;
        s1 = NB_UR;
      end
    end
  end

  assign fresh      = (next_label_q < TW'(CAP)) ? next_label_q[LW-1:0] : LBL_TOP;
  assign ab_max     = (a_q > b_q) ? a_q : b_q;
  assign ab_min     = (a_q > b_q) ? b_q : a_q;
  assign last_pix   = ((TW'(rpos_q) + TW'(1)) == total_q);

  always_comb begin
    case (cmd_i.walk_src)
      WS_MAX:  walk_start = ab_max;
      WS_MIN:  walk_start = ab_min;
      default: walk_start = i_q[LW-1:0];
    endcase
  end

  // read addresses
  always_comb begin
    if (cmd_i.pl_rd_rpos) begin
      pl_raddr = rpos_q;
    end else begin
      case (cmd_i.nb_sel)
        NB_L:    pl_raddr = pos_q - LW'(1);
        NB_UL:   pl_raddr = pos_q - w_l - LW'(1);
        NB_UP:   pl_raddr = pos_q - w_l;
        default: pl_raddr = pos_q - w_l + LW'(1);
      endcase
    end
    case (cmd_i.ep_rsel)
      EPR_PAR: ep_raddr = a_q;
      EPR_PIX: ep_raddr = pl_rdata[LW-1:0];
      default: ep_raddr = l_q;
    endcase
  end

  // write ports
  always_comb begin
    pl_we    = cmd_i.bg_wr || cmd_i.fresh_wr || cmd_i.par_wr;
    pl_waddr = pos_q;
    if (cmd_i.bg_wr) begin
      pl_wdata = {1'b1, {LW{1'b0}}};
    end else if (cmd_i.fresh_wr) begin
      pl_wdata = {1'b0, fresh};
    end else begin
      pl_wdata = {1'b0, ep_rdata};
    end

    ep_we = cmd_i.fresh_wr || cmd_i.union_wr || cmd_i.res_wr;
    if (cmd_i.fresh_wr) begin
      ep_waddr = fresh;
      ep_wdata = fresh;
    end else if (cmd_i.union_wr) begin
      ep_waddr = (ra_q > l_q) ? ra_q : l_q;
      ep_wdata = (ra_q > l_q) ? l_q : ra_q;
    end else begin
      ep_waddr = i_q[LW-1:0];
      ep_wdata = l_q;
    end

    dn_we    = cmd_i.res_wr && (l_q == i_q[LW-1:0]);
    dn_waddr = i_q[LW-1:0];
    dn_wdata = roots_q[LW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= WIDTH_RST;
      height_q     <= HEIGHT_RST;
      fg_val_q     <= FG_RST;
      x_q          <= '0;
      y_q          <= '0;
      pos_q        <= '0;
      rpos_q       <= '0;
      next_label_q <= '0;
      roots_q      <= '0;
      i_q          <= '0;
      done_q       <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      if (restart) begin
        case (cfg_idx_i)
          CFG_WIDTH:  width_q  <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i;
          default:    fg_val_q <= cfg_data_i[PIX_W-1:0];
        endcase
        x_q          <= '0;
        y_q          <= '0;
        pos_q        <= '0;
        rpos_q       <= '0;
        next_label_q <= '0;
        roots_q      <= '0;
        done_q       <= 1'b0;
      end
      if (cmd_i.accept) begin
        if (req_i.req_type == 1'b0) begin
          if (done_q) begin
            x_q          <= '0;
            y_q          <= '0;
            pos_q        <= '0;
            rpos_q       <= '0;
            next_label_q <= '0;
            roots_q      <= '0;
            done_q       <= 1'b0;
          end
        end else if (TW'(rpos_q) >= total_q) begin
          rpos_q <= '0;
        end
      end
      if (cmd_i.fresh_wr && next_label_q < TW'(CAP)) begin
        next_label_q <= next_label_q + TW'(1);
      end
      if (cmd_i.advance) begin
        if (x_last) begin
          x_q <= '0;
          if (y_last) begin
            y_q <= '0;
          end else begin
            y_q <= y_q + YW'(1);
          end
        end else begin
          x_q <= x_q + XW'(1);
        end
        pos_q <= (x_last && y_last) ? '0 : pos_q + LW'(1);
      end
      if (cmd_i.res_init) begin
        i_q     <= '0;
        roots_q <= '0;
      end
      if (cmd_i.res_wr) begin
        i_q <= i_q + TW'(1);
        if (l_q == i_q[LW-1:0]) begin
          roots_q <= roots_q + TW'(1);
        end
      end
      if (cmd_i.done_set) begin
        done_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        rpos_q <= last_pix ? '0 : rpos_q + LW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    total_q <= TW'(w_eff) * TW'(h_eff);
    if (cmd_i.accept) begin
      pix_q <= req_i.pixel;
    end
    if (cmd_i.nb_cap) begin
      nb_fg_q[cmd_i.nb_cap_idx]  <= !pl_rdata[LW];
      nb_lab_q[cmd_i.nb_cap_idx] <= pl_rdata[LW-1:0];
    end
    if (cmd_i.decide) begin
      have1_q <= have1;
      have2_q <= have2;
      a_q     <= nb_lab_q[s1];
      b_q     <= nb_lab_q[s2];
    end
    if (cmd_i.walk_init) begin
      l_q <= walk_start;
    end else if (cmd_i.walk_step) begin
      l_q <= ep_rdata;
    end
    if (cmd_i.save_ra) begin
      ra_q <= l_q;
    end
    if (cmd_i.emit) begin
      res_q.is_foreground   <= cmd_i.emit_fg;
      res_q.label           <= cmd_i.emit_fg ? LBL_W'(dn_rdata) : '0;
      res_q.component_count <= CNT_W'(roots_q);
      res_q.last            <= last_pix;
    end
  end

  bic_ram #(.W(LW + 1), .D(CAP)) u_pl_ram (
    .clk_i   (clk_i),
    .we_i    (pl_we),
    .waddr_i (pl_waddr),
    .wdata_i (pl_wdata),
    .raddr_i (pl_raddr),
    .rdata_o (pl_rdata)
  );

  bic_ram #(.W(LW), .D(CAP)) u_ep_ram (
    .clk_i   (clk_i),
    .we_i    (ep_we),
    .waddr_i (ep_waddr),
    .wdata_i (ep_wdata),
    .raddr_i (ep_raddr),
    .rdata_o (ep_rdata)
  );

  bic_ram #(.W(LW), .D(CAP)) u_dn_ram (
    .clk_i   (clk_i),
    .we_i    (dn_we),
    .waddr_i (dn_waddr),
    .wdata_i (dn_wdata),
    .raddr_i (ep_rdata),
    .rdata_o (dn_rdata)
  );

  assign status_o.pix_fg    = (pix_q == fg_val_q);
  assign status_o.done      = done_q;
  assign status_o.have1     = have1_q;
  assign status_o.have2     = have2_q;
  assign status_o.ab_differ = (a_q != b_q);
  assign status_o.walk_done = (ep_rdata >= l_q);
  assign status_o.frame_end = x_last && y_last;
  assign status_o.res_more  = (i_q < next_label_q);
  assign status_o.pl_bg     = pl_rdata[LW];

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

[test/tb_top.sv]
// self-checking testbench of the binary image component labeler
`timescale 1ns / 1ps

module tb_top;
  import bic_pkg::*;

  localparam int          PIX_CAP    = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int unsigned BG_FLAG    = 32'h8000_0000;
  localparam int          IDLE_LIMIT = 50000;
  localparam int          N_ITEMS    = 850;

  // label prediction: own copy of the frame, label stores and registers,
  // one expected label per readout of a finished frame
  class label_scoreboard;
    int unsigned pix_lab [PIX_CAP];
    int unsigned parent [PIX_CAP];
    int unsigned dense [PIX_CAP];
    int unsigned reg_w, reg_h, reg_fg;
    int unsigned col, row, fresh_lab, n_roots, rd_pos;
    bit          frame_ready;
    res_t        expected_q[$];
    int          n_bad;

    function new();
      reg_w  = MAX_WIDTH_DEF;
      reg_h  = MAX_HEIGHT_DEF;
      reg_fg = 255;
      n_bad  = 0;
      restart();
    endfunction

    function void restart();
      col = 0; row = 0; fresh_lab = 0; n_roots = 0; rd_pos = 0;
      frame_ready = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned vmax);
      if (v == 0) return 1;
      return (v > vmax) ? vmax : v;
    endfunction

    function void write_reg(cfg_idx_e idx, int unsigned v);
      case (idx)
        CFG_WIDTH:  reg_w  = v & 10'h3ff;
        CFG_HEIGHT: reg_h  = v & 10'h3ff;
        CFG_FG:     reg_fg = v & 8'hff;
        default:    return;
      endcase
      restart();
    endfunction

    function bit fg_at(int unsigned i);
      return i < PIX_CAP && (pix_lab[i] & BG_FLAG) == 0;
    endfunction

    function int unsigned lab_at(int unsigned i);
      return (i < PIX_CAP) ? (pix_lab[i] & ~BG_FLAG) : 0;
    endfunction

    function int unsigned root_of(int unsigned l);
      while (l < PIX_CAP && parent[l] < l) l = parent[l];
      return (l < PIX_CAP) ? l : 0;
    endfunction

    function void load(int unsigned pix);
      int unsigned w, h, x, y, p, i1, i2, lab, a, b, ra, rb, n;
      bit lf, ul, up, ur, h1, h2;
      w = clamp_dim(reg_w, MAX_WIDTH_DEF);
      h = clamp_dim(reg_h, MAX_HEIGHT_DEF);
      x = col; y = row;
      p = y * w + x;
      if (p >= PIX_CAP) p = PIX_CAP - 1;
      if (pix == reg_fg) begin
        lf = x > 0 && fg_at(p - 1);
        ul = x > 0 && y > 0 && fg_at(p - w - 1);
        up = y > 0 && fg_at(p - w);
        ur = y > 0 && x + 1 < w && fg_at(p - w + 1);
        h1 = 0; h2 = 0; i1 = 0; i2 = 0;
        if (lf) begin
          h1 = 1; i1 = p - 1;
          if (y > 0) begin
            if (!ul) begin
              if (up) begin h2 = 1; i2 = p - w; end
              else if (ur) begin h2 = 1; i2 = p - w + 1; end
            end else if (!up && ur) begin
              h2 = 1; i2 = p - w + 1;
            end
          end
        end else if (y > 0) begin
          if (up) begin h1 = 1; i1 = p - w; end
          else if (ul) begin
            h1 = 1; i1 = p - w - 1;
            if (ur) begin h2 = 1; i2 = p - w + 1; end
          end else if (ur) begin h1 = 1; i1 = p - w + 1; end
        end
        if (h1) begin
          n = lab_at(i1);
          lab = (n < PIX_CAP) ? parent[n] : 0;
        end else begin
          lab = (fresh_lab < PIX_CAP) ? fresh_lab : PIX_CAP - 1;
          parent[lab] = lab;
          if (fresh_lab < PIX_CAP) fresh_lab++;
        end
        pix_lab[p] = lab;
        // two differing neighbour labels: larger root points to smaller
        if (h2) begin
          a = lab_at(i1); b = lab_at(i2);
          if (a != b) begin
            ra = root_of(a > b ? a : b);
            rb = root_of(a > b ? b : a);
            if (ra > rb) parent[ra] = rb;
            else parent[rb] = ra;
          end
        end
      end else begin
        pix_lab[p] = BG_FLAG;
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) begin
          row = 0;
          // resolve: flatten to roots, number roots densely
          n = 0;
          for (int unsigned i = 0; i < fresh_lab && i < PIX_CAP; i++) begin
            ra = root_of(i);
            parent[i] = ra;
            if (ra == i) begin dense[i] = n; n++; end
          end
          n_roots = n;
          frame_ready = 1;
        end
      end
    endfunction

    function void note_request(req_t r);
      int unsigned w, h, tot, v, rt;
      res_t e;
      if (!r.req_type) begin
        if (frame_ready) restart();
        load(r.pixel);
        return;
      end
      if (!frame_ready) return;
      w = clamp_dim(reg_w, MAX_WIDTH_DEF);
      h = clamp_dim(reg_h, MAX_HEIGHT_DEF);
      tot = w * h;
      if (rd_pos >= tot || rd_pos >= PIX_CAP) rd_pos = 0;
      v = pix_lab[rd_pos];
      e = '0;
      if ((v & BG_FLAG) == 0) begin
        rt = (v < PIX_CAP) ? parent[v] : 0;
        e.is_foreground = 1'b1;
        e.label = LBL_W'((rt < PIX_CAP) ? dense[rt] : 0);
      end
      e.component_count = CNT_W'(n_roots);
      e.last = (rd_pos + 1 == tot);
      rd_pos = e.last ? 0 : rd_pos + 1;
      expected_q = {expected_q, e};
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result: %p", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.is_foreground !== e.is_foreground || got.label !== e.label ||
          got.component_count !== e.component_count || got.last !== e.last) begin
        n_bad++;
        if (n_bad <= 10)
          $display({"label mismatch at %0t: expected fg %0d lab %0d cnt %0d last %0d,",
                    " got fg %0d lab %0d cnt %0d last %0d"},
                   $realtime, e.is_foreground, e.label, e.component_count, e.last,
                   got.is_foreground, got.label, got.component_count, got.last);
      end
    endfunction
  endclass

  logic                 clk_i, rst_ni;
  logic                 start, busy;
  req_t                 req_i;
  logic                 result_valid_o;
  res_t                 result_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  label_scoreboard sb;
  int              idle_cycles;
  int              n_sent;

  binary_image_component_labeler i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  // both monitors sample pre-edge values, so the order of events is irrelevant
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) sb.note_request(req_i);
    if (rst_ni && result_valid_o) sb.check_result(result_o);
  end

  // watchdog: cycles without any request or result transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // gap before a transfer: mostly none or short, now and then long
  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = (r < 65) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // one request transfer; start stays high into the next call when no gap
  task automatic send_req(logic kind, logic [PIX_W-1:0] pix);
    idle_gap();
    start <= 1'b1;
    req_i <= '{req_type: kind, pixel: pix};
    do @(posedge clk_i); while (busy);
    n_sent++;
  endtask

  // block idle: all readouts in, loads finished, resolve sweep done
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_regs(int unsigned w, int unsigned h, int unsigned fg);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_WIDTH;  cfg_data_i <= CFG_W'(w);
    @(posedge clk_i);
    sb.write_reg(CFG_WIDTH, w);
    cfg_idx_i <= CFG_HEIGHT; cfg_data_i <= CFG_W'(h);
    @(posedge clk_i);
    sb.write_reg(CFG_HEIGHT, h);
    cfg_idx_i <= CFG_FG;     cfg_data_i <= CFG_W'(fg & 8'hff);
    @(posedge clk_i);
    sb.write_reg(CFG_FG, fg);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // whole frame of random pixels, fg_pct percent of them figure,
  // with, if noise is set, the odd readout that is ignored while the frame is open
  task automatic load_frame(int unsigned n_pix, int fg_pct, bit noise);
    logic [PIX_W-1:0] p;
    for (int unsigned i = 0; i < n_pix; i++) begin
      if (noise && $urandom_range(0, 99) < 3) send_req(1'b1, PIX_W'($urandom));
      p = ($urandom_range(0, 99) < fg_pct) ? PIX_W'(sb.reg_fg) : PIX_W'($urandom);
      send_req(1'b0, p);
    end
  endtask

  task automatic read_frame(int unsigned n_rd);
    for (int unsigned i = 0; i < n_rd; i++) send_req(1'b1, PIX_W'($urandom));
  endtask

  initial begin
    int unsigned w, h, fg, np;
    int          sel;
    logic [PIX_W-1:0] pat [9];
    sb = new();
    n_sent = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_WIDTH;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: a u shape merges two labels through up-right; fg 255, bg 0
    write_regs(3, 3, 255);
    send_req(1'b1, 8'h00);                 // readout on an open frame: ignored
    pat = '{8'hff, 8'h00, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff};
    foreach (pat[i]) send_req(1'b0, pat[i]);
    read_frame(11);                        // runs past the end and wraps
    // register writes restart the frame; fg value zero
    write_regs(0, 1023, 0);                // width 0 used as 1, height as max
    load_frame(4, 50, 0);
    write_regs(1023, 1, 0);                // write restarts the partial frame; width as max, one row
    load_frame(512, 60, 0);
    read_frame(3);
    write_regs(1, 0, 8'h80);
    send_req(1'b0, 8'h80);
    read_frame(2);

    // random phases: mostly small frames, now and then a long single row or column
    while (n_sent < N_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        w = $urandom_range(20, 40); h = $urandom_range(0, 1);
      end else if (sel < 8) begin
        w = $urandom_range(0, 1); h = $urandom_range(20, 40);
      end else begin
        w = $urandom_range(0, 12); h = $urandom_range(0, 8);
      end
      sel = $urandom_range(0, 9);
      fg = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(0, 255);
      write_regs(w, h, fg);
      np = sb.clamp_dim(w, MAX_WIDTH_DEF) * sb.clamp_dim(h, MAX_HEIGHT_DEF);
      repeat ($urandom_range(1, 2)) begin
        load_frame(np, $urandom_range(30, 85), 1);
        sel = $urandom_range(0, 9);
        // sometimes a partial readout, so the next load discards a done frame
        read_frame((sel == 0) ? $urandom_range(0, np) : np + $urandom_range(0, 2));
      end
    end

    wait_idle();
    if (sb.n_bad == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/bic_pkg.sv
hdl/bic_ram.sv
hdl/bic_ctrl.sv
hdl/bic_dp.sv
hdl/binary_image_component_labeler.sv
test/tb_top.sv
